[src/i2cm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, command codes and phase tables of the I2C master bit engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // command codes
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_INIT    = 4'd1;
  localparam logic [3:0] CMD_START   = 4'd2;
  localparam logic [3:0] CMD_RESTART = 4'd3;
  localparam logic [3:0] CMD_STOP    = 4'd4;
  localparam logic [3:0] CMD_ACK     = 4'd5;
  localparam logic [3:0] CMD_NAK     = 4'd6;
  localparam logic [3:0] CMD_SEND    = 4'd7;
  localparam logic [3:0] CMD_READ    = 4'd8;
  localparam logic [3:0] CMD_ADDR    = 4'd9;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_TICKS    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b1;
  localparam int CFG_DATA_W = 10;

  localparam logic [9:0] DELAY_RESET = 10'd250;

  // phase counts and ack phase indexes of the byte commands
  localparam logic [5:0] SEND_PHASES  = 6'd27;
  localparam logic [5:0] READ_PHASES  = 6'd16;
  localparam logic [5:0] SEND_ACK_REL = 6'd24;
  localparam logic [5:0] SEND_ACK_SMP = 6'd25;

  // fixed phase lists, one bit per phase: pin (1 = SDA, 0 = SCL) and level
  localparam logic [3:0] FIX_PIN [7] = '{4'b0000, 4'b0001, 4'b0001, 4'b0101,
                                         4'b1010, 4'b1001, 4'b1001};
  localparam logic [3:0] FIX_LVL [7] = '{4'b0000, 4'b0011, 4'b0000, 4'b0011,
                                         4'b1100, 4'b1010, 4'b1011};

  typedef struct packed {
    logic [3:0] active_command;
    logic [5:0] phase_index;
    logic [9:0] tick_counter;
    logic [7:0] shift_byte;
    logic       scl_level;
    logic       sda_level;
    logic [7:0] received_byte;
    logic       ack_seen;
  } state_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_data;
    logic       ack_level;
  } res_t;

  // phases in a command sequence
  function automatic logic [5:0] seq_length(input logic [3:0] c);
    logic [5:0] len;
    len = 6'd0;
    if (c >= CMD_INIT && c <= CMD_START) len = 6'd2;
    else if (c >= CMD_RESTART && c <= CMD_NAK) len = 6'd4;
    else if (c == CMD_SEND || c == CMD_ADDR) len = SEND_PHASES;
    else if (c == CMD_READ) len = READ_PHASES;
    return len;
  endfunction

  // remainder by three from the bit weights 1, 2, 1, 2, 1
  function automatic logic [1:0] mod3(input logic [4:0] v);
    logic [2:0] s;
    s = {2'b00, v[0]} + {2'b00, v[2]} + {2'b00, v[4]} +
        {1'b0, v[1], 1'b0} + {1'b0, v[3], 1'b0};
    if (s >= 3'd6) s = s - 3'd6;
    else if (s >= 3'd3) s = s - 3'd3;
    return s[1:0];
  endfunction

endpackage

[src/i2cm_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm channel interfaces
// Valid/ready channels for the tick items and the result items.
// ----------------------------------------------------------------------------
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] cmd;
  logic [7:0] tx_data;
  logic       sda_in;
  modport source (output valid, cmd, tx_data, sda_in, input ready);
  modport sink (input valid, cmd, tx_data, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_data;
  logic       ack_level;
  modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_data, ack_level,
                  input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_data, ack_level,
                output ready);
endinterface

[src/i2cm_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_step
// One tick of the bit engine: command launch, phase action and phase timing.
// ----------------------------------------------------------------------------
module i2cm_step (
  input  i2cm_pkg::state_t st,
  input  logic [3:0]       cmd,
  input  logic [7:0]       tx_data,
  input  logic             sda_in,
  input  logic [9:0]       delay_ticks,
  input  logic [6:0]       device_address,
  output i2cm_pkg::state_t st_next,
  output i2cm_pkg::res_t   res
);

  logic             launch;
  logic [9:0]       dly;
  logic [9:0]       tick_inc;
  logic [5:0]       phase_inc;
  logic [1:0]       sub;
  logic [2:0]       fix_row;
  logic [1:0]       fix_col;
  logic             done;
  i2cm_pkg::state_t st_launch;

  assign launch  = (st.active_command == i2cm_pkg::CMD_NONE) &&
                   (cmd >= i2cm_pkg::CMD_INIT) && (cmd <= i2cm_pkg::CMD_ADDR);
  assign dly     = (delay_ticks == 10'd0) ? 10'd1 : delay_ticks;
  assign fix_row = st_launch.active_command[2:0];
  assign fix_col = st_launch.phase_index[1:0];
  assign sub     = i2cm_pkg::mod3(st_launch.phase_index[4:0]);

  // command launch while idle
  always_comb begin
    st_launch = st;
    if (launch) begin
      st_launch.active_command = cmd;
      st_launch.phase_index    = 6'd0;
      st_launch.tick_counter   = 10'd0;
      if (cmd == i2cm_pkg::CMD_SEND) st_launch.shift_byte = tx_data;
      else if (cmd == i2cm_pkg::CMD_ADDR) st_launch.shift_byte = {device_address, 1'b0};
      else st_launch.shift_byte = 8'd0;
    end
  end

  // phase action on the first tick of a phase, then phase timing
  always_comb begin
    st_next   = st_launch;
    done      = 1'b0;
    tick_inc  = st_launch.tick_counter + 10'd1;
    phase_inc = st_launch.phase_index + 6'd1;
    if (st_launch.active_command != i2cm_pkg::CMD_NONE) begin
      if (st_launch.tick_counter == 10'd0) begin
        if (st_launch.active_command >= i2cm_pkg::CMD_INIT &&
            st_launch.active_command <= i2cm_pkg::CMD_NAK) begin
          if (st_launch.phase_index[5:2] == 4'd0) begin
            if (i2cm_pkg::FIX_PIN[fix_row][fix_col])
              st_next.sda_level = i2cm_pkg::FIX_LVL[fix_row][fix_col];
            else
              st_next.scl_level = i2cm_pkg::FIX_LVL[fix_row][fix_col];
          end
        end else if (st_launch.active_command == i2cm_pkg::CMD_SEND ||
                     st_launch.active_command == i2cm_pkg::CMD_ADDR) begin
          if (st_launch.phase_index < i2cm_pkg::SEND_ACK_REL) begin
            if (sub == 2'd0) begin
              st_next.sda_level = st_launch.shift_byte[7];
            end else if (sub == 2'd1) begin
              st_next.scl_level = 1'b1;
            end else begin
              st_next.scl_level  = 1'b0;
              st_next.shift_byte = {st_launch.shift_byte[6:0], 1'b0};
            end
          end else if (st_launch.phase_index == i2cm_pkg::SEND_ACK_REL) begin
            st_next.sda_level = 1'b1;
          end else if (st_launch.phase_index == i2cm_pkg::SEND_ACK_SMP) begin
            st_next.scl_level = 1'b1;
            st_next.ack_seen  = sda_in;
          end else begin
            st_next.scl_level = 1'b0;
          end
        end else if (st_launch.active_command == i2cm_pkg::CMD_READ) begin
          if (!st_launch.phase_index[0]) begin
            st_next.shift_byte = {st_launch.shift_byte[6:0], sda_in};
            st_next.scl_level  = 1'b1;
          end else begin
            st_next.scl_level = 1'b0;
          end
        end
      end
      st_next.tick_counter = tick_inc;
      if (tick_inc >= dly) begin
        st_next.tick_counter = 10'd0;
        st_next.phase_index  = phase_inc;
        if (phase_inc >= i2cm_pkg::seq_length(st_launch.active_command)) begin
          if (st_launch.active_command == i2cm_pkg::CMD_READ)
            st_next.received_byte = st_next.shift_byte;
          st_next.active_command = i2cm_pkg::CMD_NONE;
          st_next.phase_index    = 6'd0;
          done                   = 1'b1;
        end
      end
    end
  end

  // result of this tick
  always_comb begin
    res.scl_out   = st_next.scl_level;
    res.sda_out   = st_next.sda_level;
    res.busy_res  = (st_next.active_command != i2cm_pkg::CMD_NONE);
    res.done_res  = done;
    res.rx_data   = st_next.received_byte;
    res.ack_level = st_next.ack_seen;
  end

endmodule

[src/i2cm_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_engine
// Input register, configuration and engine state around the tick logic.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic                           clk,
  input  logic                           rst,
  i2cm_in_if.sink                        in_ch,
  input  logic                           cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                           res_valid,
  input  logic                           res_ready,
  output i2cm_pkg::res_t                 res
);

  logic             ir_valid;
  logic [3:0]       ir_cmd;
  logic [7:0]       ir_tx_data;
  logic             ir_sda_in;
  logic             advance;
  logic [9:0]       delay_ticks;
  logic [6:0]       device_address;
  i2cm_pkg::state_t st;
  i2cm_pkg::state_t st_next;

  assign advance     = ir_valid && res_ready;
  assign in_ch.ready = !ir_valid || res_ready;
  assign res_valid   = ir_valid;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_ticks    <= i2cm_pkg::DELAY_RESET;
      device_address <= 7'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::CFG_DELAY_TICKS:    delay_ticks    <= cfg_data[9:0];
        i2cm_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ch.ready) begin
      ir_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ir_cmd     <= in_ch.cmd;
      ir_tx_data <= in_ch.tx_data;
      ir_sda_in  <= in_ch.sda_in;
    end
  end

  // tick logic
  i2cm_step u_step (
    .st             (st),
    .cmd            (ir_cmd),
    .tx_data        (ir_tx_data),
    .sda_in         (ir_sda_in),
    .delay_ticks    (delay_ticks),
    .device_address (device_address),
    .st_next        (st_next),
    .res            (res)
  );

  // engine state, updated as each transaction leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.active_command <= i2cm_pkg::CMD_NONE;
      st.phase_index    <= 6'd0;
      st.tick_counter   <= 10'd0;
      st.shift_byte     <= 8'd0;
      st.scl_level      <= 1'b1;
      st.sda_level      <= 1'b1;
      st.received_byte  <= 8'd0;
      st.ack_seen       <= 1'b1;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

[src/i2cm_skid.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cm_skid
// Result register with a skid stage, so the ready towards the engine is
// registered and a stalled receiver does not stop the next transaction.
// ----------------------------------------------------------------------------
module i2cm_skid (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  output logic           res_ready,
  input  i2cm_pkg::res_t res,
  i2cm_out_if.source     out_ch
);

  logic           out_valid;
  i2cm_pkg::res_t out_data;
  logic           skid_valid;
  i2cm_pkg::res_t skid_data;
  logic           out_free;

  assign res_ready = !skid_valid;
  assign out_free  = out_ch.ready || !out_valid;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid && res_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : res;
    end else if (res_valid && res_ready) begin
      skid_data <= res;
    end
  end

  assign out_ch.valid     = out_valid;
  assign out_ch.scl_out   = out_data.scl_out;
  assign out_ch.sda_out   = out_data.sda_out;
  assign out_ch.busy_res  = out_data.busy_res;
  assign out_ch.done_res  = out_data.done_res;
  assign out_ch.rx_data   = out_data.rx_data;
  assign out_ch.ack_level = out_data.ack_level;

endmodule

[src/i2c_master_bit_engine_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_top
// I2C master bit engine: turns commands into open-drain SCL/SDA phases.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one transaction per bus tick: cmd, tx_data and the sampled
//   sda_in. A command is taken only while the engine is idle; otherwise it is
//   dropped and the tick just advances the running sequence.
//   out_ch returns one result per tick: the SCL/SDA drive, busy, a done pulse,
//   the last read byte and the last ack level.
//   Configuration (delay_ticks, device_address) is written through cfg_we,
//   cfg_index and cfg_data while no transaction is in flight.
// Timing:
//   one transaction per cycle sustained while out_ch.ready holds; an accepted
//   tick passes the input register and the tick logic and is offered on out_ch
//   from the result register, by way of the skid stage after a stall.
// Reset:
//   rst clears the engine to idle with both lines released, delay_ticks 250
//   and device_address 0.
// Stall:
//   a held result waits in the result register, the next goes to the skid
//   stage and a third waits in the input register; in_ch.ready then drops
//   until the receiver takes a result.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_top (
  input  logic                            clk,
  input  logic                            rst,
  i2cm_in_if.sink                         in_ch,
  i2cm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [i2cm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic           res_valid;
  logic           res_ready;
  i2cm_pkg::res_t res;

  // tick processing
  i2cm_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // result buffering
  i2cm_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule
